### hdl/assert_macros.svh
// Assertion macros used by the checker file pwmpt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge outside of reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds on a rising clk_i edge outside of reset.
`define CHK_NEVER(lbl, cond, msg) \
  `CHK_ASSERT(lbl, !(cond), msg)

`endif

### hdl/pwmpt_pkg.sv
// Types, constants and helpers of the PWM prescaler and tick calculation unit.
package pwmpt_pkg;

  localparam int unsigned RATE_W = 32;
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned DIV_W  = 48;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [DIV_W-1:0] DIV_NS_INIT = DIV_W'(NS_PER_SEC << (QUO_W - 1));

  localparam logic [3:0] PRESCALE_SHIFT [8] = '{4'd0, 4'd1, 4'd2, 4'd3,
                                                4'd4, 4'd6, 4'd8, 4'd10};

  localparam logic [1:0] OUT_HIGH = 2'd3;
  localparam logic [1:0] OUT_LOW  = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG    = 2'd1;
  localparam logic [1:0] STATUS_ZERO_PERIOD = 2'd2;

  localparam logic [0:0] REG_CLOCK_RATE = 1'b0;
  localparam logic [0:0] REG_ACTIVE_LOW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_DIV_NS,
    ST_MUL_DUTY,
    ST_DIV_PERIOD
  } pwmpt_state_e;

  typedef struct packed {
    logic [31:0] prd_ns;
    logic [31:0] duty_ns;
  } pwmpt_req_t;

  typedef struct packed {
    logic [15:0] prd_ticks;
    logic [2:0]  prescaler_code;
    logic [15:0] duty_ticks;
    logic [22:0] period_word;
    logic [1:0]  status;
  } pwmpt_res_t;

  function automatic logic [22:0] pack_word(logic [15:0] cycles, logic [2:0] code,
                                            logic act_low);
    logic [3:0] states;
    states = act_low ? {OUT_HIGH, OUT_LOW} : {OUT_LOW, OUT_HIGH};
    return {code, states, cycles};
  endfunction

endpackage

### hdl/pwm_prescaler_and_tick_calculation_unit.sv
// Top level of the PWM prescaler and tick calculation unit.
// A transaction runs the rate multiply, the ns division, the duty multiply and the period
// division; a period too long for any divider ends after the rate multiply, a zero period
// is answered from idle. A new one is taken only in idle; the bit-serial shift-add
// multiplier (32 + 16 steps) and the shared restoring divider (2 x 16 steps) do the work.
// Reset: clock_rate_hz returns to 24000000, the polarity to active high, the unit to idle.
module pwm_prescaler_and_tick_calculation_unit
  import pwmpt_pkg::*;
#(
  parameter int unsigned DIVIDER_COUNT = 8,
  parameter int unsigned PERIOD_LIMIT  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  input  pwmpt_req_t  req_i,
  output logic        busy_o,
  output logic        done_o,
  output pwmpt_res_t  res_o
);

  localparam logic [63:0] CYCLE_LIMIT = 64'(PERIOD_LIMIT) * NS_PER_SEC;

  pwmpt_state_e state_q, state_d;

  logic [31:0]      rate_q;
  logic             act_low_q;
  logic [31:0]      period_q, period_d;
  logic [31:0]      duty_q, duty_d;
  logic [31:0]      mbits_q, mbits_d;
  logic [63:0]      acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             found_q, found_d;
  logic [2:0]       code_q, code_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [15:0]      cyc_q, cyc_d;
  logic             sat_q, sat_d;
  logic             done_q, done_d;
  pwmpt_res_t       res_q, res_d;

  logic             hit;
  logic [2:0]       hit_k;
  logic             pass;
  logic             ge;
  logic [DIV_W-1:0] rem_sub;
  logic [QUO_W-1:0] quo_nx;
  logic [31:0]      mcand;
  logic [63:0]      acc_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= 32'd24000000;
      act_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CLOCK_RATE: rate_q    <= cfg_wdata_i;
        REG_ACTIVE_LOW: act_low_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_k = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < DIVIDER_COUNT && cnt_q == CNT_W'(RATE_W - PRESCALE_SHIFT[k])) begin
        hit   = 1'b1;
        hit_k = 3'(k);
      end
    end
  end

  assign pass    = hit && (acc_q < CYCLE_LIMIT);
  assign ge      = rem_q >= dsr_q;
  assign rem_sub = rem_q - dsr_q;
  assign quo_nx  = {quo_q[QUO_W-2:0], ge};
  assign mcand   = (state_q == ST_MUL_RATE) ? period_q : duty_q;
  assign acc_sh  = {acc_q[62:0], 1'b0} + (mbits_q[31] ? {32'd0, mcand} : 64'd0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && req_i.prd_ns != 32'd0) state_d = ST_MUL_RATE;
      end
      ST_MUL_RATE: begin
        if (cnt_q == CNT_W'(RATE_W)) state_d = (found_q || pass) ? ST_DIV_NS : ST_IDLE;
      end
      ST_DIV_NS: begin
        if (cnt_q == CNT_W'(QUO_W - 1)) state_d = ST_MUL_DUTY;
      end
      ST_MUL_DUTY: begin
        if (cnt_q == CNT_W'(QUO_W - 1)) state_d = ST_DIV_PERIOD;
      end
      ST_DIV_PERIOD: begin
        if (cnt_q == CNT_W'(QUO_W - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    period_d = period_q;
    duty_d   = duty_q;
    mbits_d  = mbits_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    code_d   = code_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    quo_d    = quo_q;
    cyc_d    = cyc_q;
    sat_d    = sat_q;
    done_d   = 1'b0;
    res_d    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          period_d = req_i.prd_ns;
          duty_d   = req_i.duty_ns;
          mbits_d  = rate_q;
          acc_d    = '0;
          cnt_d    = '0;
          found_d  = 1'b0;
          code_d   = '0;
          if (req_i.prd_ns == 32'd0) begin
            done_d               = 1'b1;
            res_d.prd_ticks      = '0;
            res_d.prescaler_code = '0;
            res_d.duty_ticks     = '0;
            res_d.period_word    = pack_word(16'd0, 3'd0, act_low_q);
            res_d.status         = STATUS_ZERO_PERIOD;
          end
        end
      end
      ST_MUL_RATE: begin
        if (pass) begin
          found_d = 1'b1;
          code_d  = hit_k;
          rem_d   = acc_q[DIV_W-1:0];
        end
        if (cnt_q == CNT_W'(RATE_W)) begin
          cnt_d = '0;
          dsr_d = DIV_NS_INIT;
          quo_d = '0;
          if (!(found_q || pass)) begin
            done_d               = 1'b1;
            res_d.prd_ticks      = '0;
            res_d.prescaler_code = '0;
            res_d.duty_ticks     = '0;
            res_d.period_word    = '0;
            res_d.status         = STATUS_TOO_LONG;
          end
        end else begin
          acc_d   = acc_sh;
          mbits_d = {mbits_q[30:0], 1'b0};
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_DIV_NS: begin
        if (ge) rem_d = rem_sub;
        quo_d = quo_nx;
        dsr_d = dsr_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          cyc_d   = quo_nx;
          mbits_d = {quo_nx, 16'd0};
          acc_d   = '0;
          cnt_d   = '0;
        end
      end
      ST_MUL_DUTY: begin
        acc_d   = acc_sh;
        mbits_d = {mbits_q[30:0], 1'b0};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          rem_d = acc_sh[DIV_W-1:0];
          dsr_d = {1'b0, period_q, 15'd0};
          quo_d = '0;
          cnt_d = '0;
        end
      end
      ST_DIV_PERIOD: begin
        if (ge) rem_d = rem_sub;
        quo_d = quo_nx;
        dsr_d = dsr_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '0) sat_d = rem_q[DIV_W-1:16] >= period_q;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          cnt_d                = '0;
          done_d               = 1'b1;
          res_d.prd_ticks      = cyc_q;
          res_d.prescaler_code = code_q;
          res_d.duty_ticks     = sat_q ? 16'hFFFF : quo_nx;
          res_d.period_word    = pack_word(cyc_q, code_q, act_low_q);
          res_d.status         = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    duty_q   <= duty_d;
    mbits_q  <= mbits_d;
    acc_q    <= acc_d;
    code_q   <= code_d;
    rem_q    <= rem_d;
    dsr_q    <= dsr_d;
    quo_q    <= quo_d;
    cyc_q    <= cyc_d;
    sat_q    <= sat_d;
    res_q    <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/pwmpt_checker.sv
// Port-level checker of the PWM prescaler and tick calculation unit, with its bind.
`include "assert_macros.svh"

module pwmpt_checker
  import pwmpt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input pwmpt_req_t req_i,
  input logic       busy_o,
  input logic       done_o,
  input pwmpt_res_t res_o
);

  `CHK_ASSERT(a_start_busy, (start_i && !busy_o && req_i.prd_ns != 32'd0) |=> busy_o, "busy did not rise after an accepted transaction")
  `CHK_ASSERT(a_zero_period, (start_i && !busy_o && req_i.prd_ns == 32'd0) |=> (done_o && res_o.status == STATUS_ZERO_PERIOD), "zero period transaction not answered at once")
  `CHK_NEVER(a_done_busy, done_o && busy_o, "result shown while busy")
  `CHK_ASSERT(a_word_ok, (done_o && res_o.status == STATUS_OK) |-> (res_o.period_word[15:0] == res_o.prd_ticks && res_o.period_word[22:20] == res_o.prescaler_code), "period word does not match the counts")
  `CHK_ASSERT(a_too_long, (done_o && res_o.status == STATUS_TOO_LONG) |-> (res_o.period_word == 23'd0 && res_o.duty_ticks == 16'd0 && res_o.prd_ticks == 16'd0), "too long period result not cleared")

endmodule

bind pwm_prescaler_and_tick_calculation_unit pwmpt_checker u_pwmpt_checker (.*);
